// File: design/prfq_pkg.sv
// shared types and constants for the per-flow round-robin queue
`timescale 1ns / 1ps
`default_nettype none
package prfq_pkg;

  typedef enum logic [1:0] {
    REQ_ENQ   = 2'd0,
    REQ_DEQ   = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_ENQ     = 3'd0,
    ST_DEQ     = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FLUSHED = 3'd3,
    ST_FULL    = 3'd4,
    ST_NOTHING = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  flow_id;
    logic [15:0] packet_handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  out_flow;
    logic [15:0] out_handle;
    logic        last;
    logic [10:0] pending_total;
  } out_item_t;

endpackage
`default_nettype wire

// File: design/prfq_front.sv
// front end: request intake and a two-entry queue toward the scheduler
`timescale 1ns / 1ps
`default_nettype none
module prfq_front
  import prfq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          q_valid,
  input  wire logic     q_ready,
  output in_item_t      q_item
);

  in_item_t  slot [2];
  logic      wr_ptr;
  logic      rd_ptr;
  logic [1:0] fill;
  logic      push;
  logic      pop;

  // unknown request types are dropped at intake
  assign in_ready = (fill != 2'd2);
  assign push = in_valid && in_ready && (in_item.req_type != REQ_NONE);
  assign pop  = q_valid && q_ready;
  assign q_valid = (fill != 2'd0);
  assign q_item  = slot[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_item;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// File: design/prfq_back.sv
// back end: per-flow fifo state, round-robin search and result register
`timescale 1ns / 1ps
`default_nettype none
module prfq_back
  import prfq_pkg::*;
#(
  parameter int FLOWS       = 64,
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     q_valid,
  output logic          q_ready,
  input  wire in_item_t q_item,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_item
);

  localparam int FW = (FLOWS > 1) ? $clog2(FLOWS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS = FLOWS * (2 ** QW);
  localparam int LOGF = 6;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_LOOK = 5'b00100,
    S_READ = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  // per-flow head slot and handle count
  typedef struct packed {
    logic [QW-1:0] head;
    logic [CW-1:0] cnt;
  } ptr_t;

  state_t                 state;
  logic [HANDLE_BITS-1:0] mem [SLOTS];
  logic [HANDLE_BITS-1:0] mem_q;
  ptr_t                   ptr_mem [FLOWS];
  ptr_t                   ptr_q;
  logic [FLOWS-1:0]       active;
  logic [FW-1:0]          last_served;
  logic [10:0]            total;
  req_type_t              req;
  logic                   fid_ok;
  logic [FW-1:0]          cur;
  logic [FW-1:0]          scan;
  logic [FW:0]            scan_n;
  logic [QW-1:0]          w_head;
  logic [CW-1:0]          w_cnt;
  logic [HANDLE_BITS-1:0] hold_handle;
  logic [FW-1:0]          fid;
  logic                   fid_in_ok;
  logic                   req_ok;
  logic                   res_free;
  logic [QW-1:0]          look_head;
  logic [CW-1:0]          look_cnt;
  logic                   enq_ok;
  logic [QW:0]            slot_sum;
  logic [QW-1:0]          slot;
  logic [QW-1:0]          head_inc;
  logic                   scan_last;
  logic [FW-1:0]          ptr_raddr;
  logic                   ptr_we;
  ptr_t                   ptr_wdata;
  logic                   mem_we;
  logic                   res_load;
  out_item_t              res_next;

  assign fid       = FW'(q_item.flow_id);
  assign fid_in_ok = ({26'd0, q_item.flow_id} < 32'(FLOWS));
  assign q_ready   = (state == S_IDLE);
  assign req_ok    = q_valid && q_ready;
  assign res_free  = !out_valid || out_ready;

  // an inactive flow reads as empty whatever its pointer entry holds
  assign look_head = active[cur] ? ptr_q.head : '0;
  assign look_cnt  = active[cur] ? ptr_q.cnt : '0;
  assign enq_ok    = fid_ok && (look_cnt < CW'(QUEUE_DEPTH));

  // tail slot and head advance, wrapping at the queue depth
  assign slot_sum  = {1'b0, look_head} + (QW+1)'(look_cnt);
  assign slot      = (slot_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                     QW'(slot_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(slot_sum);
  assign head_inc  = (w_head == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(w_head + 1'b1);
  assign scan_last = (scan == FW'(FLOWS - 1));

  // pointer memory read address
  always_comb begin
    unique case (state)
      S_IDLE:  ptr_raddr = fid;
      S_SCAN:  ptr_raddr = scan;
      default: ptr_raddr = cur;
    endcase
  end

  // result and memory write decisions
  always_comb begin
    res_load = 1'b0;
    res_next = '0;
    res_next.last = 1'b1;
    res_next.pending_total = total;
    ptr_we = 1'b0;
    ptr_wdata.head = look_head;
    ptr_wdata.cnt = look_cnt;
    mem_we = 1'b0;
    unique case (state)
      S_SCAN: begin
        if (!active[scan] && scan_n == (FW+1)'(FLOWS - 1) && res_free) begin
          res_load = 1'b1;
          res_next.status = ST_EMPTY;
        end
      end
      S_LOOK: begin
        if (req == REQ_ENQ && res_free) begin
          res_load = 1'b1;
          if (enq_ok) begin
            mem_we = 1'b1;
            ptr_we = 1'b1;
            ptr_wdata.cnt = look_cnt + 1'b1;
            res_next.status = ST_ENQ;
            res_next.pending_total = total + 11'd1;
          end else begin
            res_next.status = ST_FULL;
          end
        end else if (req == REQ_FLUSH && !(fid_ok && active[cur]) && res_free) begin
          res_load = 1'b1;
          res_next.status = ST_NOTHING;
        end
      end
      S_EMIT: begin
        if (res_free) begin
          res_load = 1'b1;
          ptr_we = 1'b1;
          ptr_wdata.head = head_inc;
          ptr_wdata.cnt = w_cnt - 1'b1;
          res_next.out_flow = LOGF'(cur);
          res_next.out_handle = 16'(mem_q);
          if (req == REQ_FLUSH) begin
            res_next.status = ST_FLUSHED;
            res_next.last = (w_cnt == CW'(1));
            res_next.pending_total = total - 11'(w_cnt);
          end else begin
            res_next.status = ST_DEQ;
            res_next.pending_total = total - 11'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // handle memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[{cur, slot}] <= hold_handle;
    mem_q <= mem[{cur, w_head}];
  end

  // per-flow pointer memory, registered read
  always_ff @(posedge clk) begin
    if (ptr_we) ptr_mem[cur] <= ptr_wdata;
    ptr_q <= ptr_mem[ptr_raddr];
  end

  // control, active flags and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      active <= '0;
      last_served <= FW'(FLOWS - 1);
      total <= '0;
      req <= REQ_ENQ;
      fid_ok <= 1'b0;
      cur <= '0;
      scan <= '0;
      scan_n <= '0;
      w_head <= '0;
      w_cnt <= '0;
      hold_handle <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_ok) begin
            req <= req_type_t'(q_item.req_type);
            fid_ok <= fid_in_ok;
            cur <= fid;
            hold_handle <= HANDLE_BITS'(q_item.packet_handle);
            scan <= (last_served == FW'(FLOWS - 1)) ? '0 : FW'(last_served + 1'b1);
            scan_n <= '0;
            state <= (q_item.req_type == REQ_DEQ) ? S_SCAN : S_LOOK;
          end
        end
        // one flow examined per cycle, wrapping
        S_SCAN: begin
          if (active[scan]) begin
            cur <= scan;
            last_served <= scan;
            state <= S_LOOK;
          end else if (scan_n == (FW+1)'(FLOWS - 1)) begin
            if (res_free) state <= S_IDLE;
          end else begin
            scan_n <= scan_n + 1'b1;
            scan <= scan_last ? '0 : FW'(scan + 1'b1);
          end
        end
        // pointer entry of the selected flow is available
        S_LOOK: begin
          if (req == REQ_ENQ) begin
            if (res_free) begin
              if (enq_ok) begin
                active[cur] <= 1'b1;
                total <= total + 11'd1;
              end
              state <= S_IDLE;
            end
          end else if (req == REQ_FLUSH && !(fid_ok && active[cur])) begin
            if (res_free) state <= S_IDLE;
          end else begin
            w_head <= look_head;
            w_cnt <= look_cnt;
            state <= S_READ;
          end
        end
        S_READ: state <= S_EMIT;
        // pop the head once the result register is free
        S_EMIT: begin
          if (res_free) begin
            w_head <= head_inc;
            w_cnt <= w_cnt - 1'b1;
            total <= total - 11'd1;
            if (w_cnt == CW'(1)) active[cur] <= 1'b0;
            state <= (req == REQ_FLUSH && w_cnt != CW'(1)) ? S_READ : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) out_item <= res_next;
  end

endmodule
`default_nettype wire

// File: design/per_flow_round_robin_queue_unit.sv
// top level of the per-flow round-robin queue
// Requests enter on in_valid/in_ready with an in_item_t payload: enqueue,
// dequeue or flush. Results leave on out_valid/out_ready as out_item_t.
// A two-entry request queue separates intake from the scheduler, so new
// requests are taken while a result waits for the receiver.
// Steps: enqueue and flush of an idle flow read the flow's pointer entry and
// then load their result; a dequeue first scans from the flow after the one
// last served, skipping idle flows, then reads the pointer entry and the head
// handle; an empty dequeue scans every flow. Flush returns its handles one by
// one, each after its own handle read (the pointer and handle reads are
// registered). The scheduler takes a new request only when the last is done.
// Reset (rst, synchronous) clears the active flags and totals and marks the
// highest flow as last served; handle and pointer memories are not
// cleared, an inactive flow reads as empty.
// A stalled receiver holds the result register and the scheduler waits.
// Unknown request types are swallowed with no result.
`timescale 1ns / 1ps
`default_nettype none
module per_flow_round_robin_queue_unit
  import prfq_pkg::*;
#(
  parameter int FLOWS       = 64,
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_item
);

  logic     q_valid;
  logic     q_ready;
  in_item_t q_item;

  prfq_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .q_valid, .q_ready, .q_item
  );

  prfq_back #(
    .FLOWS(FLOWS), .QUEUE_DEPTH(QUEUE_DEPTH), .HANDLE_BITS(HANDLE_BITS)
  ) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .out_item
  );

endmodule
`default_nettype wire

// File: design/prfq_checker.sv
// port-level checks for the per-flow round-robin queue
`timescale 1ns / 1ps
`default_nettype none
module prfq_checker
  import prfq_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result dropped under stall");

  // no result right after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  // single-result statuses are always last
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_FLUSHED |-> out_item.last)
    else $error("single result not last");

  // empty answer means nothing pending
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_EMPTY |-> out_item.pending_total == 11'd0)
    else $error("empty with pending handles");

endmodule

bind per_flow_round_robin_queue_unit prfq_checker u_prfq_checker (
  .clk, .rst, .out_valid, .out_ready, .out_item
);
`default_nettype wire
